@@ rtl/core/smv_pkg.sv @@
package smv_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 10;
	localparam int CMD_W     = 2;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NZ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
		logic                     row_end;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] row_sum;
		logic [IDX_W-1:0]         row_index;
		logic                     last_row;
	} result_t;

	// Work carried from the input register into the multiply stage
	typedef struct packed {
		logic              nz;
		logic              close;
		logic              in_range;
		logic [DATA_W-1:0] value;
	} s1_op_t;

endpackage

@@ rtl/core/smv_ifs.sv @@
interface smv_item_if import smv_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smv_result_if import smv_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smv_cfg_if import smv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/smv_ram.sv @@
module smv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/smv_accum.sv @@
module smv_accum import smv_pkg::*; #(
	parameter int ROW_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s1,
	input  s1_op_t            op_s1,
	input  logic [DATA_W-1:0] rd_data,
	input  logic [CFG_W-1:0]  num_rows,
	output logic              s1_take,
	smv_result_if.source      result
);

	localparam int RW  = $clog2(ROW_DEPTH);
	localparam int RCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	logic              vld_s2;
	logic              nz_s2;
	logic              close_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q;
	logic [RW-1:0]     row_cnt_q;
	logic              res_vld_q;
	result_t           res_q;

	logic              out_free;
	logic              go_s2;
	logic              emit;
	logic [DATA_W-1:0] sum;
	logic [RCW-1:0]    rows_use;
	logic [RCW-1:0]    cnt_ext;
	logic [RCW-1:0]    cnt_inc;
	logic              is_last;
	logic              wrap;

	assign out_free = !res_vld_q || result.ready;
	assign go_s2    = vld_s2 && (!close_s2 || out_free);
	assign emit     = go_s2 && close_s2;
	assign s1_take  = vld_s1 && (!vld_s2 || go_s2);

	assign sum = acc_q + prod_s2;

	always_comb begin
		if (num_rows == '0) begin
			rows_use = RCW'(1);
		end else if (RCW'(num_rows) > RCW'(ROW_DEPTH)) begin
			rows_use = RCW'(ROW_DEPTH);
		end else begin
			rows_use = RCW'(num_rows);
		end
	end

	assign cnt_ext = RCW'(row_cnt_q);
	assign cnt_inc = cnt_ext + RCW'(1);
	assign is_last = (cnt_ext == rows_use - RCW'(1));
	assign wrap    = (cnt_inc >= rows_use);

	// Multiply stage: low word of the product is all the sum needs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_take) begin
			vld_s2 <= 1'b1;
		end else if (go_s2) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			nz_s2    <= op_s1.nz;
			close_s2 <= op_s1.close;
			prod_s2  <= op_s1.in_range ? DATA_W'(op_s1.value * rd_data) : '0;
		end
	end

	// Accumulate; a closing request clears the sum and advances the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			row_cnt_q <= '0;
		end else if (go_s2) begin
			if (close_s2) begin
				acc_q     <= '0;
				row_cnt_q <= wrap ? '0 : RW'(cnt_inc);
			end else begin
				acc_q <= sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (emit) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.row_sum   <= nz_s2 ? sum : '0;
			res_q.row_index <= cnt_ext[IDX_W-1:0];
			res_q.last_row  <= is_last;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!emit |=> $stable(row_cnt_q))
		else $error("row counter moved without a row result");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> acc_q == '0)
		else $error("accumulator not cleared after row result");

	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last |=> row_cnt_q == '0)
		else $error("row counter did not wrap after last row");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !result.ready |-> !emit)
		else $error("row result overwritten while stalled");

endmodule

@@ rtl/core/csr_sparse_matvec.sv @@
// Channel  Dir  Handshake      Payload
// item     in   valid/ready    cmd, index, value, row_end
// result   out  valid/ready    row_sum, row_index, last_row
// cfg      in   valid/ready    index (0 num_rows, 1 num_cols), data
//
// One item per cycle unless the pipeline stalls. A row result is registered after
// its request passes the input register with vector read, product, accumulate.
// Vector loads write the vector RAM at acceptance and give no result.
// arst_n clears the sum, the row counter and the valid bits; the vector RAM
// keeps no reset. A stalled result holds the pipeline only when the next
// request in the product stage also closes a row.
module csr_sparse_matvec import smv_pkg::*; #(
	parameter int VECTOR_DEPTH = 1024,
	parameter int ROW_DEPTH    = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	smv_item_if.sink     item,
	smv_result_if.source result,
	smv_cfg_if.sink      cfg
);

	localparam int AW = $clog2(VECTOR_DEPTH);
	localparam int XW = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [31:0] VDEPTH = 32'(VECTOR_DEPTH);

	logic [CFG_W-1:0]  num_rows_q;
	logic [CFG_W-1:0]  num_cols_q;
	logic              vld_s1;
	s1_op_t            op_s1;
	logic              s1_take;
	logic              accept;
	logic              is_load;
	logic              is_nz;
	logic              is_empty;
	logic              in_depth;
	logic [XW-1:0]     idx_x;
	logic [AW-1:0]     addr;
	logic [DATA_W-1:0] rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_W'(1024);
			num_cols_q <= CFG_W'(1024);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NUM_ROWS: num_rows_q <= cfg.data;
				REG_NUM_COLS: num_cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign item.ready = !vld_s1 || s1_take;
	assign accept     = item.valid && item.ready;

	assign is_load  = (item.data.cmd == CMD_LOAD);
	assign is_nz    = (item.data.cmd == CMD_NZ);
	assign is_empty = (item.data.cmd == CMD_EMPTY);
	assign in_depth = (32'(item.data.index) < VDEPTH);
	assign idx_x    = XW'(item.data.index);
	assign addr     = idx_x[AW-1:0];

	// Loads and unused codes never enter the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= is_nz || is_empty;
		end else if (s1_take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.nz       <= is_nz;
			op_s1.close    <= is_empty || (is_nz && item.data.row_end);
			op_s1.in_range <= is_nz && in_depth &&
				(CFG_W'(item.data.index) < num_cols_q);
			op_s1.value    <= item.data.value;
		end
	end

	smv_ram #(
		.WIDTH (DATA_W),
		.DEPTH (VECTOR_DEPTH)
	) u_vec_ram (
		.clk   (clk),
		.we    (accept && is_load && in_depth),
		.waddr (addr),
		.wdata (item.data.value),
		.re    (accept && is_nz),
		.raddr (addr),
		.rdata (rd_data)
	);

	smv_accum #(
		.ROW_DEPTH (ROW_DEPTH)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.op_s1    (op_s1),
		.rd_data  (rd_data),
		.num_rows (num_rows_q),
		.s1_take  (s1_take),
		.result   (result)
	);

endmodule

@@ sim/tb_csr_sparse_matvec.sv @@
`timescale 1ns / 1ps

module tb_csr_sparse_matvec;
	import smv_pkg::*;

	localparam int VEC_DEPTH   = 1024;
	localparam int ROW_LIMIT   = 1024;
	localparam int WRAP_ROWS   = 150;
	localparam int DRAIN_WAIT  = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	smv_item_if   item_ch ();
	smv_result_if result_ch ();
	smv_cfg_if    cfg_ch ();

	csr_sparse_matvec u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_len;
	int hold_serial;
	int mismatches;
	int rows_checked;
	int requests_sent;
	int reg_writes;
	int unsigned cycle_count;

	// Local copy of the block state
	logic [CFG_W-1:0]  num_rows_q;
	logic [CFG_W-1:0]  num_cols_q;
	logic [DATA_W-1:0] vector_mem [0:VEC_DEPTH-1];
	bit                vector_loaded [0:VEC_DEPTH-1];
	logic [IDX_W-1:0]  loaded_cols [$];
	logic [DATA_W-1:0] row_acc;
	logic [IDX_W-1:0]  row_ctr;
	result_t           expected_rows [$];

	function automatic void fold_request(input item_t req);
		logic [CFG_W-1:0]  rows;
		logic [DATA_W-1:0] sum;
		logic              closes;
		result_t           row;
		if (num_rows_q == '0)
			rows = CFG_W'(1);
		else if (num_rows_q > CFG_W'(ROW_LIMIT))
			rows = CFG_W'(ROW_LIMIT);
		else
			rows = num_rows_q;
		closes = 1'b0;
		sum = '0;
		case (req.cmd)
			CMD_LOAD: begin
				vector_mem[req.index] = req.value;
				if (!vector_loaded[req.index]) begin
					vector_loaded[req.index] = 1'b1;
					loaded_cols.push_back(req.index);
				end
			end
			CMD_NZ: begin
				// columns past num_cols add nothing but still count
				if ({1'b0, req.index} < num_cols_q)
					row_acc = row_acc + req.value * vector_mem[req.index];
				closes = req.row_end;
				sum = row_acc;
			end
			CMD_EMPTY: begin
				closes = 1'b1;
			end
			default: ;
		endcase
		if (closes) begin
			row.row_sum   = sum;
			row.row_index = row_ctr;
			row.last_row  = ({1'b0, row_ctr} == rows - 1'b1);
			row_acc = '0;
			row_ctr = ({1'b0, row_ctr} + 1'b1 >= rows) ? '0 : row_ctr + 1'b1;
			expected_rows.push_back(row);
		end
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			default: return $urandom();
		endcase
	endfunction

	// Only columns already loaded are ever read
	function automatic logic [IDX_W-1:0] pick_column();
		return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
				expected_rows.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected row sum %h index %0d last %0b",
						result_ch.data.row_sum, result_ch.data.row_index,
						result_ch.data.last_row);
			end else begin
				want = expected_rows.pop_front();
				rows_checked++;
				if (result_ch.data.row_sum !== want.row_sum ||
					result_ch.data.row_index !== want.row_index ||
					result_ch.data.last_row !== want.last_row) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("row mismatch: sum exp %h got %h, index exp %0d got %0d, last exp %0b got %0b",
							want.row_sum, result_ch.data.row_sum, want.row_index,
							result_ch.data.row_index, want.last_row, result_ch.data.last_row);
				end
			end
		end
	end

	// Result side: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_serial) begin
				hold_seen = hold_serial;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// All tasks below start and end at a falling edge
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
		input logic [DATA_W-1:0] val, input logic row_end);
		item_t req;
		req.cmd = cmd;
		req.index = idx;
		req.value = val;
		req.row_end = row_end;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= req;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		fold_request(req);
		requests_sent++;
	endtask

	task automatic end_burst();
		item_ch.valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_NUM_ROWS: num_rows_q = val;
			REG_NUM_COLS: num_cols_q = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_row(input int nz_count);
		if (nz_count == 0) begin
			send_request(CMD_EMPTY, IDX_W'($urandom()), pick_value(), 1'($urandom_range(1)));
		end else begin
			for (int i = 0; i < nz_count; i++)
				send_request(CMD_NZ, pick_column(), pick_value(), i == nz_count - 1);
		end
	endtask

	task automatic send_load();
		send_request(CMD_LOAD, IDX_W'($urandom_range(VEC_DEPTH - 1)), pick_value(),
			1'($urandom_range(1)));
	endtask

	// Mostly well-formed rows, some loads, some junk
	task automatic run_traffic(input int count);
		int sent;
		int roll;
		int nz;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 20) begin
				send_load();
				sent++;
			end else if (roll < 24) begin
				send_request(CMD_UNUSED, IDX_W'($urandom()), $urandom(),
					1'($urandom_range(1)));
			end else if (roll < 30) begin
				// row cut short by an empty-row request
				nz = $urandom_range(1, 3);
				for (int i = 0; i < nz; i++)
					send_request(CMD_NZ, pick_column(), pick_value(), 1'b0);
				send_request(CMD_EMPTY, IDX_W'($urandom()), pick_value(),
					1'($urandom_range(1)));
				sent += nz + 1;
			end else begin
				nz = $urandom_range(0, 5);
				send_row(nz);
				sent += (nz == 0) ? 1 : nz;
			end
		end
		end_burst();
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(CMD_LOAD, 10'd0, 32'h7fff_ffff, 1'b1);
		send_request(CMD_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
		send_request(CMD_LOAD, 10'd341, 32'hffff_ffff, 1'b0);
		send_request(CMD_LOAD, 10'd682, 32'h0000_0001, 1'b0);
		send_request(CMD_NZ, 10'd0, 32'h7fff_ffff, 1'b0);
		send_request(CMD_NZ, 10'd1023, 32'h8000_0000, 1'b0);
		send_request(CMD_NZ, 10'd341, 32'hffff_ffff, 1'b1);
		send_request(CMD_EMPTY, 10'd0, 32'h0000_0000, 1'b0);
		send_request(CMD_EMPTY, 10'd1023, 32'hffff_ffff, 1'b1);
		send_request(CMD_UNUSED, 10'd1023, 32'hffff_ffff, 1'b1);
		// partial row dropped by an empty row, then a fresh row
		send_request(CMD_NZ, 10'd682, 32'h1234_5678, 1'b0);
		send_request(CMD_EMPTY, 10'd682, 32'h0000_0000, 1'b0);
		send_request(CMD_NZ, 10'd682, 32'h0000_0005, 1'b1);
		end_burst();
		wait_drain();

		write_reg(REG_NUM_COLS, 11'd1);
		write_reg(REG_UNUSED, 11'h7ff);
		send_request(CMD_NZ, 10'd1023, 32'h0000_0007, 1'b0);
		send_request(CMD_NZ, 10'd0, 32'h0000_0002, 1'b1);
		end_burst();
		wait_drain();

		// shrink the row count under a counter already past it
		write_reg(REG_NUM_ROWS, 11'd1);
		send_request(CMD_EMPTY, 10'd5, 32'h0000_0001, 1'b0);
		send_request(CMD_EMPTY, 10'd6, 32'h0000_0001, 1'b0);
		end_burst();
		wait_drain();

		write_reg(REG_NUM_ROWS, 11'd0);
		write_reg(REG_NUM_COLS, 11'd0);
		send_request(CMD_NZ, 10'd0, 32'h0000_0003, 1'b1);
		end_burst();
		wait_drain();

		write_reg(REG_NUM_ROWS, 11'd2047);
		write_reg(REG_NUM_COLS, 11'd2047);
		send_request(CMD_NZ, 10'd1023, 32'h0000_0002, 1'b1);
		send_request(CMD_LOAD, 10'd1023, 32'h0000_0003, 1'b0);
		send_request(CMD_NZ, 10'd1023, 32'h0000_0003, 1'b1);
		end_burst();
		wait_drain();
	endtask

	// Run the row counter through a full wrap
	task automatic test_row_wrap();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_NUM_ROWS, CFG_W'(WRAP_ROWS));
		write_reg(REG_NUM_COLS, 11'd1024);
		for (int i = 0; i < WRAP_ROWS + 8; i++)
			send_request(CMD_EMPTY, IDX_W'($urandom()), $urandom(), 1'($urandom_range(1)));
		end_burst();
		wait_drain();
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] rows_set [0:5];
		logic [CFG_W-1:0] cols_set [0:5];
		int               send_set [0:3];
		int               recv_set [0:3];
		rows_set = '{11'd1024, 11'd1, 11'd5, 11'd2047, 11'd0, 11'd2};
		cols_set = '{11'd1024, 11'd300, 11'd1, 11'd0, 11'd2047, 11'd64};
		send_set = '{0, 71, 0, 12};
		recv_set = '{0, 0, 71, 12};
		for (int p = 0; p < 6; p++) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
			write_reg(REG_NUM_ROWS, rows_set[p]);
			write_reg(REG_NUM_COLS, cols_set[p]);
			send_idle_pct = send_set[p % 4];
			recv_stall_pct = recv_set[p % 4];
			repeat (8) send_load();
			run_traffic(90);
			wait_drain();
		end
	endtask

	// Hold the result side off long enough to back up the input
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_NUM_ROWS, 11'd37);
		write_reg(REG_NUM_COLS, 11'd1024);
		hold_len = 400;
		hold_serial++;
		for (int i = 0; i < 40; i++)
			send_row($urandom_range(0, 2));
		end_burst();
		wait_drain();
	endtask

	task automatic test_input_pause();
		send_idle_pct = 12;
		recv_stall_pct = 12;
		run_traffic(25);
		wait_drain();
		run_traffic(25);
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 0;
		hold_serial = 0;
		mismatches = 0;
		rows_checked = 0;
		requests_sent = 0;
		reg_writes = 0;
		cycle_count = 0;
		num_rows_q = 11'd1024;
		num_cols_q = 11'd1024;
		row_acc = '0;
		row_ctr = '0;
		for (int i = 0; i < VEC_DEPTH; i++) begin
			vector_mem[i] = '0;
			vector_loaded[i] = 1'b0;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_row_wrap();
		test_random_traffic();
		test_output_hold();
		test_input_pause();

		$display("%0d requests sent, %0d row sums checked, %0d register writes", requests_sent,
			rows_checked, reg_writes);
		$display("covered directed corners, a full row wrap, six register settings and stalls");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatching rows", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/smv_pkg.sv
rtl/core/smv_ifs.sv
rtl/core/smv_ram.sv
rtl/core/smv_accum.sv
rtl/core/csr_sparse_matvec.sv
sim/tb_csr_sparse_matvec.sv
